@@ rtl/u2dasc_pkg.sv @@
package u2dasc_pkg;

  localparam int FIELD_BITS = 32;
  localparam int DIGIT_BITS = 4;
  localparam int CHAR_BITS  = 6;

  localparam logic [CHAR_BITS-1:0]  ASCII_ZERO  = 6'd48;
  localparam logic [DIGIT_BITS-1:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [DIGIT_BITS-1:0] BCD_ADJ     = 4'd3;

  typedef logic [DIGIT_BITS-1:0] bcd_digit_t;

  // per-cycle operation shared by every cell of the chain
  typedef logic [1:0] cell_op_t;
  localparam cell_op_t OP_HOLD  = 2'd0;
  localparam cell_op_t OP_CLEAR = 2'd1;
  localparam cell_op_t OP_CONV  = 2'd2;
  localparam cell_op_t OP_MOVE  = 2'd3;

endpackage

@@ rtl/unsigned_to_decimal_ascii.sv @@
// a value is converted by shift-add-3 through the digit chain, one bit per cycle
// for min(VALUE_BITS,32) bits, then the digits move out from the top down; leading
// zeros are dropped without a beat, but the units digit always goes out. The block
// takes one item at a time: in_stall holds off a new value until the last digit is issued.
// reset (rst, synchronous) returns the controller to idle and drops any output beat.
module unsigned_to_decimal_ascii #(
  parameter int VALUE_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [u2dasc_pkg::FIELD_BITS-1:0]      value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [u2dasc_pkg::CHAR_BITS-1:0]       digit_char,
  output logic                                   last_digit
);
  import u2dasc_pkg::*;

  localparam int VALUE_EFF = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
  // digits of 2^VALUE_EFF - 1
  localparam int NDIG      = (VALUE_EFF * 301) / 1000 + 1;
  localparam int CW        = $clog2(VALUE_EFF + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]           state, state_next;
  logic [CW-1:0]        cnt, cnt_next;
  logic                 started, started_next;
  logic [VALUE_EFF-1:0] val, val_next;
  logic                 out_valid_next;
  logic [CHAR_BITS-1:0] digit_char_next;
  logic                 last_digit_next;
  cell_op_t             op;
  bcd_digit_t           digits [NDIG];
  logic                 carries [NDIG];
  bcd_digit_t           top;
  logic                 out_free;

  genvar i;
  generate
    for (i = 0; i < NDIG; i++) begin : g_cell
      if (i == 0) begin : g_first
        u2dasc_cell u_cell (
          .clk      (clk),
          .op       (op),
          .lo_bit   (val[VALUE_EFF-1]),
          .lo_digit ('0),
          .carry    (carries[i]),
          .digit    (digits[i])
        );
      end else begin : g_rest
        u2dasc_cell u_cell (
          .clk      (clk),
          .op       (op),
          .lo_bit   (carries[i-1]),
          .lo_digit (digits[i-1]),
          .carry    (carries[i]),
          .digit    (digits[i])
        );
      end
    end
  endgenerate

  assign top      = digits[NDIG-1];
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    started_next    = started;
    val_next        = val;
    op              = OP_HOLD;
    digit_char_next = digit_char;
    last_digit_next = last_digit;
    out_valid_next  = out_valid && out_stall;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          val_next   = value[VALUE_EFF-1:0];
          op         = OP_CLEAR;
          cnt_next   = CW'(VALUE_EFF - 1);
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        op       = OP_CONV;
        val_next = {val[VALUE_EFF-2:0], 1'b0};
        if (cnt == '0) begin
          cnt_next     = CW'(NDIG);
          started_next = 1'b0;
          state_next   = S_EMIT;
        end else begin
          cnt_next = cnt - CW'(1);
        end
      end
      S_EMIT: begin
        // leading zero: drop it, but the units digit always goes out
        if (!started && top == '0 && cnt != CW'(1)) begin
          op       = OP_MOVE;
          cnt_next = cnt - CW'(1);
        end else if (out_free) begin
          op              = OP_MOVE;
          started_next    = 1'b1;
          cnt_next        = cnt - CW'(1);
          out_valid_next  = 1'b1;
          digit_char_next = CHAR_BITS'(ASCII_ZERO + {{(CHAR_BITS-DIGIT_BITS){1'b0}}, top});
          last_digit_next = (cnt == CW'(1));
          if (cnt == CW'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt        <= cnt_next;
    started    <= started_next;
    val        <= val_next;
    digit_char <= digit_char_next;
    last_digit <= last_digit_next;
  end

`ifndef ASSERT_OFF
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (digit_char >= ASCII_ZERO && digit_char <= CHAR_BITS'(ASCII_ZERO + 6'd9)))
    else $error("digit character outside '0'..'9'");

  a_accept_starts_conv: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_CONV))
    else $error("accepted beat did not start conversion");

  a_run_ends_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && state_next == S_IDLE) |=> (out_valid && last_digit))
    else $error("run ended without a final digit beat");

  a_run_no_gap: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_digit) |=> out_valid)
    else $error("gap inside a digit run");
`endif

endmodule

@@ rtl/u2dasc_cell.sv @@
module u2dasc_cell (
  input  logic                   clk,
  input  u2dasc_pkg::cell_op_t   op,
  input  logic                   lo_bit,
  input  u2dasc_pkg::bcd_digit_t lo_digit,
  output logic                   carry,
  output u2dasc_pkg::bcd_digit_t digit
);
  import u2dasc_pkg::*;

  bcd_digit_t adj;

  // add three to a digit of five or more before the shift so the doubled digit carries out as decimal
  always_comb begin
    adj = (digit >= BCD_ADJ_MIN) ? bcd_digit_t'(digit + BCD_ADJ) : digit;
  end

  assign carry = adj[DIGIT_BITS-1];

  always_ff @(posedge clk) begin
    unique case (op)
      OP_HOLD:  digit <= digit;
      OP_CLEAR: digit <= '0;
      OP_CONV:  digit <= {adj[DIGIT_BITS-2:0], lo_bit};
      OP_MOVE:  digit <= lo_digit;
    endcase
  end

endmodule

@@ verif/tb.sv @@
module tb;
  import u2dasc_pkg::*;

  localparam int VALUE_BITS     = 32;
  localparam int MAX_DIGITS     = 20;
  localparam int RANDOM_NUMBERS = 290;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 60;

  typedef struct {
    logic [FIELD_BITS-1:0] number;
    bit                    drain;
  } send_item_t;

  typedef struct {
    logic [CHAR_BITS-1:0] ch;
    logic                 last;
  } digit_beat_t;

  logic                  clk;
  logic                  rst        = 1'b1;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic [FIELD_BITS-1:0] value      = '0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic [CHAR_BITS-1:0]  digit_char;
  logic                  last_digit;

  send_item_t  numbers_to_send[$];
  digit_beat_t digits_due[$];
  int          numbers_accepted = 0;
  int          error_count      = 0;
  int          idle_cycles      = 0;

  int burst_left = 4;
  int gap_left   = 0;

  int stall_mode  = 0;
  int stall_left  = 50;
  int stall_phase = 0;

  unsigned_to_decimal_ascii #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .digit_char(digit_char),
    .last_digit(last_digit)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // decimal digits of one number, most significant first, flag on the last
  task automatic push_decimal_digits(input logic [FIELD_BITS-1:0] number);
    logic [63:0]  rest;
    logic [63:0]  mask;
    logic [3:0]   digs[MAX_DIGITS];
    int           count;
    digit_beat_t  beat;
    mask  = (VALUE_BITS >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_BITS) - 64'd1);
    rest  = {32'd0, number} & mask;
    count = 0;
    do begin
      digs[count] = 4'(rest % 64'd10);
      rest        = rest / 64'd10;
      count++;
    end while (rest != 0 && count < MAX_DIGITS);
    for (int k = 0; k < count; k++) begin
      beat.ch   = CHAR_BITS'(ASCII_ZERO + CHAR_BITS'(digs[count - 1 - k]));
      beat.last = (k == count - 1);
      digits_due.push_back(beat);
    end
  endtask

  task automatic queue_number(input logic [FIELD_BITS-1:0] number, input bit drain);
    send_item_t item;
    item.number = number;
    item.drain  = drain;
    numbers_to_send.push_back(item);
  endtask

  // sender: bursts of beats separated by random gaps
  always @(posedge clk) begin : driver
    bit take;
    take = in_valid && !in_stall;
    if (take) begin
      push_decimal_digits(value);
      numbers_accepted++;
    end
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || take) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (numbers_to_send.size() > 0 &&
                   !(numbers_to_send[0].drain && digits_due.size() != 0)) begin
        in_valid <= 1'b1;
        value    <= numbers_to_send[0].number;
        numbers_to_send.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: check each digit beat, stall on a mode that changes now and then
  always @(posedge clk) begin : monitor
    digit_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (digits_due.size() == 0) begin
        report_mismatch($sformatf("digit beat 0x%0h with nothing due", digit_char));
      end else begin
        want = digits_due.pop_front();
        if (digit_char !== want.ch)
          report_mismatch($sformatf("digit_char %0d, want %0d", digit_char, want.ch));
        if (last_digit !== want.last)
          report_mismatch($sformatf("last_digit %0b, want %0b", last_digit, want.last));
      end
    end
    stall_phase++;
    stall_left--;
    if (stall_left <= 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= 1'($urandom_range(0, 1));
      end
      2: begin
        // heavy back-pressure: stall unless stall_phase is a multiple of four
        out_stall <= (stall_phase % 4) != 0;
      end
      default: begin
        out_stall <= ($urandom_range(0, 9) == 0);
      end
    endcase
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int          total;
    int          pick;
    int          ndig;
    longint      lo;
    longint      hi;
    logic [31:0] number;

    // extremes, digit-count boundaries and bit patterns
    queue_number(32'd0, 1'b0);
    queue_number(32'd1, 1'b0);
    queue_number(32'd9, 1'b0);
    queue_number(32'd10, 1'b0);
    queue_number(32'd99, 1'b0);
    queue_number(32'd100, 1'b0);
    queue_number(32'd999, 1'b0);
    queue_number(32'd1000, 1'b0);
    queue_number(32'd10000, 1'b0);
    queue_number(32'd65535, 1'b0);
    queue_number(32'd65536, 1'b0);
    queue_number(32'd999999999, 1'b0);
    queue_number(32'd1000000000, 1'b1);
    queue_number(32'd1234567890, 1'b0);
    queue_number(32'h7FFFFFFF, 1'b0);
    queue_number(32'h80000000, 1'b0);
    queue_number(32'h55555555, 1'b0);
    queue_number(32'hAAAAAAAA, 1'b0);
    queue_number(32'd4000000000, 1'b0);
    queue_number(32'hFFFFFFFE, 1'b0);
    queue_number(32'hFFFFFFFF, 1'b0);
    queue_number(32'd0, 1'b0);
    queue_number(32'd3, 1'b0);

    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        number = $urandom;
      end else if (pick == 2) begin
        number = $urandom_range(9, 0);
      end else begin
        // spread over digit counts so short runs are as common as long ones
        ndig = $urandom_range(10, 2);
        lo   = 1;
        for (int d = 1; d < ndig; d++) lo = lo * 10;
        hi   = (ndig == 10) ? 64'hFFFFFFFF : lo * 10 - 1;
        number = $urandom_range(32'(hi), 32'(lo));
      end
      queue_number(number, ($urandom_range(0, 29) == 0) || (i == 0));
    end
    total = numbers_to_send.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (numbers_accepted < total) @(posedge clk);
    while (digits_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/u2dasc_pkg.sv
rtl/u2dasc_cell.sv
rtl/unsigned_to_decimal_ascii.sv
verif/tb.sv
